### rtl/dfs_pkg.sv
`default_nettype none
package dfs_pkg;

    // Largest graph the engine holds; node indices are five bits wide.
    localparam int MAX_NODES = 32;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_REM  = 3'd1,
        OP_TEST = 3'd2,
        OP_FULL = 3'd3,
        OP_DEP  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        K_DONE  = 3'd0,
        K_EDGE  = 3'd1,
        K_NODE  = 3'd2,
        K_CYCLE = 3'd3,
        K_ERROR = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        COL_WHITE = 2'd0,
        COL_GRAY  = 2'd1,
        COL_BLACK = 2'd2
    } colour_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ROOT,
        ST_LOAD,
        ST_SCAN,
        ST_CHECK,
        ST_EMIT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

### rtl/dfs_scan.sv
`default_nettype none
// Neighbour scan unit: from a start index, finds the lowest set bit at or
// above it in a row, limited to the nodes in use.
module dfs_scan #(
    parameter int N  = 32,
    parameter int IW = 5
) (
    input  wire logic [N-1:0]  row,
    input  wire logic [IW-1:0] from_idx,
    input  wire logic [IW:0]   limit,
    output logic               found,
    output logic [IW-1:0]      idx
);
    logic [N-1:0] masked;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            masked[i] = row[i] && (i >= int'(from_idx)) && (i < int'(limit));
        end
        found = 1'b0;
        idx   = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                found = 1'b1;
                idx   = IW'(i);
            end
        end
    end
endmodule
`default_nettype wire

### rtl/dfs_topological_sort_engine_core.sv
`default_nettype none
// Depth-first topological sort engine. A command is taken when start is high
// and busy is low; results come back one beat per cycle on the result ports,
// each marked by out_valid for exactly one cycle, and the receiver cannot hold
// them off. Edge add, remove and test answer with a single beat, registered
// from the done state, and no new command is taken until it has gone out. A
// sort first whitens every entry of the colour table and then walks the graph:
// the root state tries each root candidate in turn, the load, scan and check
// states run every time a node comes to the top of the stack, which happens
// once when it is pushed and once more each time a child returns to it, and a
// neighbour that is found already finished costs another pass through scan and
// check. The walk is followed by one beat per emitted node and a closing beat;
// a cycle report is a single beat instead of the list. The scan of one
// adjacency row is done by a single shared priority unit that is reused for
// every step of the walk. MAX_NODES is fixed in the package. node_count is
// clamped to 1..MAX_NODES.
module dfs_topological_sort_engine_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] op,
    input  wire logic [4:0] from_node,
    input  wire logic [4:0] to_node,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_wdata,
    output logic            out_valid,
    output logic [2:0]      kind,
    output logic [4:0]      node,
    output logic            edge_present,
    output logic            last
);
    localparam int MAX_NODES = dfs_pkg::MAX_NODES;
    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = IW + 1;

    // Adjacency row memory, colour table, walk stack and order buffer.
    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [1:0]           col_mem [MAX_NODES];
    logic [IW-1:0]        stk_node [MAX_NODES];
    logic [CW-1:0]        stk_next [MAX_NODES];
    logic [IW-1:0]        ord_mem [MAX_NODES];

    dfs_pkg::state_t state_reg, state_next;
    logic [CW-1:0] ncount_reg;
    logic [2:0]    op_reg;
    logic [IW-1:0] from_reg, to_reg;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] root_reg, root_next;
    logic [IW-1:0] v_reg, v_next;
    logic [CW-1:0] k_reg, k_next;
    logic [MAX_NODES-1:0] row_reg;
    logic          cand_reg;
    logic [IW-1:0] w_reg;

    logic          sc_found;
    logic [IW-1:0] sc_idx;
    logic [5:0]    cfg_clamped;
    logic          from_ok, to_ok;

    // Result beat register.
    logic       ov_reg;
    logic [2:0] kind_reg;
    logic [4:0] node_reg;
    logic       ep_reg, last_reg;

    assign from_ok = {1'b0, from_reg} < ncount_reg;
    assign to_ok   = {1'b0, to_reg} < ncount_reg;

    // One shared scan unit serves every neighbour search of the walk.
    dfs_scan #(.N(MAX_NODES), .IW(IW)) u_scan (
        .row      (row_reg),
        .from_idx (k_reg[IW-1:0]),
        .limit    ((k_reg >= CW'(MAX_NODES)) ? CW'(0) : ncount_reg),
        .found    (sc_found),
        .idx      (sc_idx)
    );

    always_comb
    begin
        if (cfg_wdata == 6'd0)
            cfg_clamped = 6'd1;
        else if (int'(cfg_wdata) > MAX_NODES)
            cfg_clamped = 6'(MAX_NODES);
        else
            cfg_clamped = cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ncount_reg <= CW'(MAX_NODES);
        else if (cfg_we)
            ncount_reg <= CW'(cfg_clamped);
    end

    // Adjacency is cleared at reset; it is small enough to live in flops.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                adj_mem[i] <= '0;
            end
        end
        else if (state_reg == dfs_pkg::ST_DONE && from_ok && to_ok)
        begin
            if (op_reg == dfs_pkg::OP_ADD)
                adj_mem[from_reg][to_reg] <= 1'b1;
            else if (op_reg == dfs_pkg::OP_REM)
                adj_mem[from_reg][to_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dfs_pkg::ST_IDLE;
            sp_reg    <= '0;
            emit_reg  <= '0;
            idx_reg   <= '0;
            root_reg  <= '0;
            v_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            emit_reg  <= emit_next;
            idx_reg   <= idx_next;
            root_reg  <= root_next;
            v_reg     <= v_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg   <= op;
            from_reg <= from_node;
            to_reg   <= to_node;
        end
    end

    // Colour table, stack, order buffer and scan register writes.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            dfs_pkg::ST_CLEAR:
            begin
                col_mem[idx_reg[IW-1:0]] <= dfs_pkg::COL_WHITE;
            end
            dfs_pkg::ST_ROOT:
            begin
                if (state_next == dfs_pkg::ST_LOAD)
                begin
                    col_mem[root_reg[IW-1:0]] <= dfs_pkg::COL_GRAY;
                    stk_node[0] <= root_reg[IW-1:0];
                    stk_next[0] <= '0;
                end
            end
            dfs_pkg::ST_LOAD:
            begin
                row_reg <= adj_mem[stk_node[sp_reg[IW-1:0] - IW'(1)]];
            end
            dfs_pkg::ST_SCAN:
            begin
                cand_reg <= sc_found;
                w_reg    <= sc_idx;
            end
            dfs_pkg::ST_CHECK:
            begin
                if (!cand_reg)
                begin
                    col_mem[v_reg] <= dfs_pkg::COL_BLACK;
                    if (int'(emit_reg) < MAX_NODES)
                        ord_mem[emit_reg[IW-1:0]] <= v_reg;
                end
                else if (col_mem[w_reg] == dfs_pkg::COL_WHITE)
                begin
                    stk_next[sp_reg[IW-1:0] - IW'(1)] <= CW'(w_reg) + CW'(1);
                    col_mem[w_reg] <= dfs_pkg::COL_GRAY;
                    stk_node[sp_reg[IW-1:0]] <= w_reg;
                    stk_next[sp_reg[IW-1:0]] <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        emit_next  = emit_reg;
        idx_next   = idx_reg;
        root_next  = root_reg;
        v_next     = v_reg;
        k_next     = k_reg;
        unique case (state_reg)
            dfs_pkg::ST_IDLE:
            begin
                if (start && !busy)
                begin
                    idx_next  = '0;
                    emit_next = '0;
                    sp_next   = '0;
                    root_next = (op == dfs_pkg::OP_DEP) ? CW'(from_node) : '0;
                    if (op == dfs_pkg::OP_FULL
                        || (op == dfs_pkg::OP_DEP && {1'b0, from_node} < ncount_reg))
                        state_next = dfs_pkg::ST_CLEAR;
                    else
                        state_next = dfs_pkg::ST_DONE;
                end
            end
            dfs_pkg::ST_CLEAR:
            begin
                idx_next = idx_reg + CW'(1);
                if (int'(idx_reg) == MAX_NODES - 1)
                begin
                    // The root state uses the index as a walked-once flag.
                    idx_next = '0;
                    state_next = dfs_pkg::ST_ROOT;
                end
            end
            dfs_pkg::ST_ROOT:
            begin
                if (op_reg == dfs_pkg::OP_DEP)
                begin
                    if (idx_reg != '0)
                    begin
                        idx_next = '0;
                        state_next = dfs_pkg::ST_EMIT;
                    end
                    else
                    begin
                        idx_next = CW'(1);
                        sp_next  = CW'(1);
                        state_next = dfs_pkg::ST_LOAD;
                    end
                end
                else if (root_reg >= ncount_reg)
                begin
                    idx_next = '0;
                    state_next = (emit_reg == ncount_reg) ? dfs_pkg::ST_EMIT
                                                          : dfs_pkg::ST_DONE;
                end
                else if (col_mem[root_reg[IW-1:0]] == dfs_pkg::COL_WHITE)
                begin
                    sp_next = CW'(1);
                    state_next = dfs_pkg::ST_LOAD;
                end
                else
                    root_next = root_reg + CW'(1);
            end
            dfs_pkg::ST_LOAD:
            begin
                v_next = stk_node[sp_reg[IW-1:0] - IW'(1)];
                k_next = stk_next[sp_reg[IW-1:0] - IW'(1)];
                state_next = dfs_pkg::ST_SCAN;
            end
            dfs_pkg::ST_SCAN:
            begin
                state_next = dfs_pkg::ST_CHECK;
            end
            dfs_pkg::ST_CHECK:
            begin
                if (cand_reg && col_mem[w_reg] == dfs_pkg::COL_BLACK)
                begin
                    k_next = CW'(w_reg) + CW'(1);
                    state_next = dfs_pkg::ST_SCAN;
                end
                else if (cand_reg && col_mem[w_reg] == dfs_pkg::COL_WHITE)
                begin
                    sp_next = sp_reg + CW'(1);
                    state_next = dfs_pkg::ST_LOAD;
                end
                else
                begin
                    if (!cand_reg && int'(emit_reg) < MAX_NODES)
                        emit_next = emit_reg + CW'(1);
                    sp_next = sp_reg - CW'(1);
                    if (sp_reg == CW'(1))
                    begin
                        state_next = dfs_pkg::ST_ROOT;
                        if (op_reg != dfs_pkg::OP_DEP)
                            root_next = root_reg + CW'(1);
                    end
                    else
                        state_next = dfs_pkg::ST_LOAD;
                end
            end
            dfs_pkg::ST_EMIT:
            begin
                if (idx_reg == emit_reg)
                    state_next = dfs_pkg::ST_IDLE;
                else
                    idx_next = idx_reg + CW'(1);
            end
            dfs_pkg::ST_DONE:
            begin
                state_next = dfs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Result beat, registered from the emit and done states.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= (state_reg == dfs_pkg::ST_EMIT) || (state_reg == dfs_pkg::ST_DONE);
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= dfs_pkg::K_DONE;
        node_reg <= '0;
        ep_reg   <= 1'b0;
        last_reg <= 1'b1;
        if (state_reg == dfs_pkg::ST_EMIT)
        begin
            if (idx_reg != emit_reg)
            begin
                kind_reg <= dfs_pkg::K_NODE;
                node_reg <= 5'(ord_mem[idx_reg[IW-1:0]]);
                last_reg <= 1'b0;
            end
        end
        else if (state_reg == dfs_pkg::ST_DONE)
        begin
            if (op_reg == dfs_pkg::OP_FULL)
                kind_reg <= dfs_pkg::K_CYCLE;
            else if (op_reg > dfs_pkg::OP_TEST || !from_ok || !to_ok)
                kind_reg <= dfs_pkg::K_ERROR;
            else if (op_reg == dfs_pkg::OP_TEST)
            begin
                kind_reg <= dfs_pkg::K_EDGE;
                ep_reg   <= adj_mem[from_reg][to_reg];
            end
        end
    end

    assign busy         = (state_reg != dfs_pkg::ST_IDLE) || ov_reg;
    assign out_valid    = ov_reg;
    assign kind         = kind_reg;
    assign node         = node_reg;
    assign edge_present = ep_reg;
    assign last         = last_reg;
endmodule
`default_nettype wire

### bench/tb_dfs_topological_sort_engine_core.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_dfs_topological_sort_engine_core;

    localparam int MAXN = dfs_pkg::MAX_NODES;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int CMD_DEPTH = 512;
    localparam int EXP_DEPTH = 16384;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] src;
        logic [4:0] dst;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] node;
        logic       present;
        logic       last;
    } beat_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [2:0] op;
    logic [4:0] from_node;
    logic [4:0] to_node;
    logic       cfg_we;
    logic [5:0] cfg_wdata;
    logic       out_valid;
    logic [2:0] kind;
    logic [4:0] node;
    logic       edge_present;
    logic       last;

    dfs_topological_sort_engine_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .from_node(from_node), .to_node(to_node),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .out_valid(out_valid), .kind(kind), .node(node),
        .edge_present(edge_present), .last(last)
    );

    // Shadow of the graph and of the node count, updated as commands are
    // accepted by the driver.
    logic [MAXN-1:0]  graph [MAXN];
    int               active_nodes;
    dfs_pkg::colour_t shade [MAXN];
    logic [4:0]       path_node [MAXN];
    int               path_next [MAXN];
    logic [4:0]       post_list [MAXN];
    int               post_len;

    // Pending commands and expected beats, each read from rd and filled at wr.
    cmd_t  cmd_store [CMD_DEPTH];
    int    cmd_wr;
    int    cmd_rd;
    beat_t exp_store [EXP_DEPTH];
    int    exp_wr;
    int    exp_rd;

    int  cycle_count;
    int  mismatches;
    int  beats_checked;
    int  sorts_seen;
    int  cycles_seen;
    bit  cfg_pending;
    logic [5:0] cfg_value;

    // Gaps between bursts from the sender.
    int burst_left;
    int gap_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic add_beat(input beat_t b);
        exp_store[exp_wr] = b;
        exp_wr++;
    endtask

    // Depth-first walk from one root, emitting in post-order. A node that
    // meets a gray neighbour is abandoned and stays gray.
    task automatic dfs_from(input int root);
        int sp;
        int v;
        int k;
        int w;
        bit pushed;
        bit dropped;
        shade[root] = dfs_pkg::COL_GRAY;
        path_node[0] = root[4:0];
        path_next[0] = 0;
        sp = 1;
        while (sp > 0)
        begin
            v = path_node[sp-1];
            k = path_next[sp-1];
            pushed = 0;
            dropped = 0;
            while (k < active_nodes && !pushed && !dropped)
            begin
                w = k;
                k++;
                if (graph[v][w])
                begin
                    if (shade[w] == dfs_pkg::COL_WHITE)
                    begin
                        path_next[sp-1] = k;
                        shade[w] = dfs_pkg::COL_GRAY;
                        path_node[sp] = w[4:0];
                        path_next[sp] = 0;
                        sp++;
                        pushed = 1;
                    end
                    else if (shade[w] == dfs_pkg::COL_GRAY)
                        dropped = 1;
                end
            end
            if (!pushed)
            begin
                if (!dropped)
                begin
                    shade[v] = dfs_pkg::COL_BLACK;
                    if (post_len < MAXN)
                    begin
                        post_list[post_len] = v[4:0];
                        post_len++;
                    end
                end
                sp--;
            end
        end
    endtask

    function automatic beat_t mk(input dfs_pkg::kind_t k, input logic [4:0] n,
                                 input logic p, input logic l);
        beat_t b;
        b.kind = k;
        b.node = n;
        b.present = p;
        b.last = l;
        return b;
    endfunction

    // Work out the result beats of one accepted command.
    task automatic predict_command(input cmd_t c);
        int i;
        if (c.op <= dfs_pkg::OP_TEST)
        begin
            if (c.src >= active_nodes || c.dst >= active_nodes)
                add_beat(mk(dfs_pkg::K_ERROR, 5'd0, 1'b0, 1'b1));
            else if (c.op == dfs_pkg::OP_ADD)
            begin
                graph[c.src][c.dst] = 1'b1;
                add_beat(mk(dfs_pkg::K_DONE, 5'd0, 1'b0, 1'b1));
            end
            else if (c.op == dfs_pkg::OP_REM)
            begin
                graph[c.src][c.dst] = 1'b0;
                add_beat(mk(dfs_pkg::K_DONE, 5'd0, 1'b0, 1'b1));
            end
            else
                add_beat(mk(dfs_pkg::K_EDGE, 5'd0, graph[c.src][c.dst], 1'b1));
            return;
        end
        if (c.op > dfs_pkg::OP_DEP || (c.op == dfs_pkg::OP_DEP && c.src >= active_nodes))
        begin
            add_beat(mk(dfs_pkg::K_ERROR, 5'd0, 1'b0, 1'b1));
            return;
        end
        sorts_seen++;
        for (i = 0; i < MAXN; i++)
            shade[i] = dfs_pkg::COL_WHITE;
        post_len = 0;
        if (c.op == dfs_pkg::OP_FULL)
        begin
            for (i = 0; i < active_nodes; i++)
                if (shade[i] == dfs_pkg::COL_WHITE)
                    dfs_from(i);
            if (post_len != active_nodes)
            begin
                cycles_seen++;
                add_beat(mk(dfs_pkg::K_CYCLE, 5'd0, 1'b0, 1'b1));
                return;
            end
        end
        else
            dfs_from(c.src);
        for (i = 0; i < post_len; i++)
            add_beat(mk(dfs_pkg::K_NODE, post_list[i], 1'b0, 1'b0));
        add_beat(mk(dfs_pkg::K_DONE, 5'd0, 1'b0, 1'b1));
    endtask

    // Driver: start stays high across back-to-back commands within a burst;
    // between bursts it drops for a random gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_command('{op: op, src: from_node, dst: to_node});
                cmd_rd++;
                if (burst_left > 0)
                    burst_left = burst_left - 1;
            end
            if (cfg_pending)
            begin
                cfg_we <= 1'b1;
                cfg_wdata <= cfg_value;
                active_nodes = (cfg_value == 0) ? 1 :
                               (cfg_value > MAXN) ? MAXN : int'(cfg_value);
                cfg_pending = 0;
                start <= 1'b0;
            end
            else
            begin
                cfg_we <= 1'b0;
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end
                else if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    start <= 1'b0;
                end
                else if (cmd_rd < cmd_wr)
                begin
                    start <= 1'b1;
                    op <= cmd_store[cmd_rd].op;
                    from_node <= cmd_store[cmd_rd].src;
                    to_node <= cmd_store[cmd_rd].dst;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed beat is compared with the oldest expectation.
    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid)
        begin
            got = mk(dfs_pkg::kind_t'(kind), node, edge_present, last);
            if (exp_rd >= exp_wr)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat kind=%0d node=%0d present=%0b last=%0b",
                             kind, node, edge_present, last);
            end
            else
            begin
                want = exp_store[exp_rd];
                exp_rd++;
                beats_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected kind=%0d node=%0d present=%0b last=%0b",
                                 want.kind, want.node, want.present, want.last);
                        $display("          got      kind=%0d node=%0d present=%0b last=%0b",
                                 kind, node, edge_present, last);
                    end
                end
            end
        end
    end

    task automatic queue_raw(input logic [2:0] o, input logic [4:0] s, input logic [4:0] d);
        cmd_store[cmd_wr] = '{op: o, src: s, dst: d};
        cmd_wr++;
    endtask

    task automatic queue_cmd(input dfs_pkg::op_t o, input int s, input int d);
        queue_raw(o, s[4:0], d[4:0]);
    endtask

    // Wait until every queued command is taken and every beat has arrived,
    // then give the block time to settle before touching its register.
    task automatic drain();
        while (cmd_rd < cmd_wr || exp_rd < exp_wr)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_count(input int n);
        drain();
        cfg_value = n[5:0];
        cfg_pending = 1;
        while (cfg_pending)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Random phase: edge adds, removes and tests interleaved with sorts, with
    // some noise (errors, out-of-range nodes, unknown ops).
    task automatic random_phase(input int count);
        int i;
        int s;
        int d;
        int r;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, active_nodes - 1);
            d = $urandom_range(0, active_nodes - 1);
            if (r < 5)
                queue_raw(3'($urandom_range(0, 7)), 5'($urandom), 5'($urandom));
            else if (r < 45)
            begin
                // Mostly forward edges make cycles in the graph rare.
                if ($urandom_range(0, 5) != 0 && s > d)
                    queue_cmd(dfs_pkg::OP_ADD, d, s);
                else
                    queue_cmd(dfs_pkg::OP_ADD, s, d);
            end
            else if (r < 55)
                queue_cmd(dfs_pkg::OP_REM, s, d);
            else if (r < 68)
                queue_cmd(dfs_pkg::OP_TEST, s, d);
            else if (r < 84)
                queue_cmd(dfs_pkg::OP_FULL, s, d);
            else
                queue_cmd(dfs_pkg::OP_DEP, s, d);
        end
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        op = '0;
        from_node = '0;
        to_node = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        cycle_count = 0;
        mismatches = 0;
        beats_checked = 0;
        sorts_seen = 0;
        cycles_seen = 0;
        cfg_pending = 0;
        burst_left = 0;
        gap_left = 0;
        cmd_wr = 0;
        cmd_rd = 0;
        exp_wr = 0;
        exp_rd = 0;
        post_len = 0;
        active_nodes = MAXN;
        for (i = 0; i < MAXN; i++)
            graph[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty graph sort, edge extremes, a cycle, a gray abandon,
        // out-of-range nodes and unknown ops.
        queue_cmd(dfs_pkg::OP_FULL, 0, 0);
        queue_cmd(dfs_pkg::OP_ADD, 0, 31);
        queue_cmd(dfs_pkg::OP_ADD, 31, 0);
        queue_cmd(dfs_pkg::OP_TEST, 31, 0);
        queue_cmd(dfs_pkg::OP_TEST, 0, 1);
        queue_cmd(dfs_pkg::OP_FULL, 0, 0);
        queue_cmd(dfs_pkg::OP_DEP, 0, 0);
        queue_cmd(dfs_pkg::OP_REM, 31, 0);
        queue_cmd(dfs_pkg::OP_TEST, 31, 0);
        queue_cmd(dfs_pkg::OP_ADD, 1, 2);
        queue_cmd(dfs_pkg::OP_ADD, 2, 1);
        queue_cmd(dfs_pkg::OP_DEP, 1, 0);
        queue_cmd(dfs_pkg::OP_FULL, 0, 0);
        queue_cmd(dfs_pkg::OP_REM, 2, 1);
        queue_cmd(dfs_pkg::OP_DEP, 31, 0);
        queue_cmd(dfs_pkg::OP_FULL, 0, 0);
        queue_raw(3'd5, 5'd0, 5'd0);
        queue_raw(3'd7, 5'd31, 5'd31);
        set_count(4);
        queue_cmd(dfs_pkg::OP_ADD, 4, 0);
        queue_cmd(dfs_pkg::OP_TEST, 0, 31);
        queue_cmd(dfs_pkg::OP_DEP, 5, 0);
        queue_cmd(dfs_pkg::OP_FULL, 0, 0);
        set_count(1);
        queue_cmd(dfs_pkg::OP_FULL, 0, 0);
        queue_cmd(dfs_pkg::OP_ADD, 0, 0);
        queue_cmd(dfs_pkg::OP_FULL, 0, 0);
        queue_cmd(dfs_pkg::OP_REM, 0, 0);
        set_count(0);
        queue_cmd(dfs_pkg::OP_DEP, 0, 0);

        set_count(8);
        random_phase(31);
        set_count(63);
        random_phase(31);
        set_count(17);
        random_phase(31);
        drain();

        $display("checked %0d result beats over %0d sorts (%0d cycle reports)",
                 beats_checked, sorts_seen, cycles_seen);
        if (mismatches == 0 && exp_rd == exp_wr)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

`default_nettype wire

### files.f
rtl/dfs_pkg.sv
rtl/dfs_scan.sv
rtl/dfs_topological_sort_engine_core.sv
bench/tb_dfs_topological_sort_engine_core.sv
